### rtl/rrgb_pkg.sv
// ----------------------------------------------------------------------------
// rrgb_pkg
// Shared widths, register indexes and sideband structs for the range remap
// with gain and bias block.
// ----------------------------------------------------------------------------
package rrgb_pkg;

  localparam int DATA_W        = 40;          // sample and range width
  localparam int EXT_W         = DATA_W + 1;  // width of differences
  localparam int FACT_W        = 17;          // gain and bias register width
  localparam int FACT_ONE      = 65536;       // 1.0 in the factor format
  localparam int FACT_HALF     = 32768;       // 0.5 in the factor format
  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int SPLIT_W       = 21;          // low slice for partial products

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_INPUT_LOW   = 3'd0,
    CFG_INPUT_HIGH  = 3'd1,
    CFG_OUTPUT_LOW  = 3'd2,
    CFG_OUTPUT_HIGH = 3'd3,
    CFG_GAIN        = 3'd4,
    CFG_BIAS        = 3'd5,
    CFG_CLAMP       = 3'd6
  } cfg_idx_t;

  // travels with a request through the normalizing divider
  typedef struct packed {
    logic             bad;   // missing sample or empty input range
    logic             cz;    // normalized value clamps to zero
    logic             cone;  // normalized value clamps to one
    logic             uneg;  // sign of the unclamped result offset
    logic             dneg;  // output range runs downward
    logic [EXT_W-1:0] dabs;  // output range magnitude
  } front_t;

  // travels with a request through the shaping stages
  typedef struct packed {
    logic             act;   // shaping applies
    logic             bad;
    logic             uneg;
    logic             dneg;
    logic [EXT_W-1:0] dabs;
    logic             uovf;  // unclamped quotient overflowed
    logic [EXT_W-1:0] uq;    // unclamped quotient
  } side_t;

endpackage

### rtl/rrgb_div.sv
// ----------------------------------------------------------------------------
// rrgb_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag when the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module rrgb_div #(
  parameter int NW = 82,
  parameter int DW = 41,
  parameter int QW = 41,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int EW = NW + DW;

  logic          v_r    [0:QW];
  logic          ovf_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];
  logic [DW-1:0] rem_r  [0:QW-1];
  logic [DW-1:0] den_r  [0:QW-1];
  logic [QW-1:0] lo_r   [0:QW-1];
  logic [QW-1:0] q_r    [1:QW];

  logic [EW-1:0] hi_ext;

  // high part of the numerator seeds the remainder
  assign hi_ext = EW'(in_num) >> QW;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]  <= hi_ext >= EW'(in_den);
      side_r[0] <= in_side;
      rem_r[0]  <= hi_ext[DW-1:0];
      den_r[0]  <= in_den;
      lo_r[0]   <= in_num[QW-1:0];
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_r[s-1], lo_r[s-1][QW-1]};
    assign diff  = trial - {1'b0, den_r[s-1]};
    assign ge    = trial >= {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[s]  <= ovf_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end

    if (s == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) q_r[s] <= QW'(ge);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) q_r[s] <= {q_r[s-1][QW-2:0], ge};
      end
    end

    if (s < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          den_r[s] <= den_r[s-1];
          lo_r[s]  <= lo_r[s-1] << 1;
        end
      end
    end
  end

  assign out_v    = v_r[QW];
  assign out_quo  = q_r[QW];
  assign out_ovf  = ovf_r[QW];
  assign out_side = side_r[QW];

endmodule

### rtl/rrgb_shape.sv
// ----------------------------------------------------------------------------
// rrgb_shape
// One shaping step: the bias curve, or the Schlick gain curve built from it,
// on a value in [0,1]. Requests without shaping pass their value unchanged.
// ----------------------------------------------------------------------------
module rrgb_shape #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic                 in_act,
  input  logic                 in_sch,
  input  logic [FRAC_BITS:0]   in_fac,
  input  logic [FRAC_BITS:0]   in_x,
  input  logic [SW-1:0]        in_side,
  output logic                 out_v,
  output logic [FRAC_BITS:0]   out_x,
  output logic [SW-1:0]        out_side
);

  localparam int F    = FRAC_BITS;
  localparam int XW   = F + 1;
  localparam int PRW  = 2 * F + 5;
  localparam int P2W  = 2 * F + 2;
  localparam int NUMW = 3 * F + 2;
  localparam int DENW = 2 * F + 1;
  localparam logic [XW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [XW-1:0] HALF = {2'b01, {(F-1){1'b0}}};

  typedef struct packed {
    logic          act;
    logic          sch;
    logic          hi;
    logic          bad;
    logic [XW-1:0] x;
    logic [SW-1:0] side;
  } dside_t;

  // stage A: pick factor and argument
  logic          a_v_r, a_act_r, a_sch_r, a_hi_r;
  logic [XW-1:0] a_f_r, a_xp_r, a_x_r;
  logic [SW-1:0] a_side_r;
  logic [XW-1:0] a_f_nxt, a_xp_nxt;
  logic          a_hi_nxt;
  logic [XW:0]   x2;

  assign x2 = {in_x, 1'b0};

  always_comb begin
    a_f_nxt  = in_fac;
    a_xp_nxt = in_x;
    a_hi_nxt = 1'b0;
    if (in_sch) begin
      if (in_x < HALF) begin
        a_xp_nxt = x2[XW-1:0];
      end else begin
        a_f_nxt  = ONE - in_fac;
        a_xp_nxt = XW'(x2 - {1'b0, ONE});
        a_hi_nxt = 1'b1;
      end
    end
  end

  // stage B: products of the bias formula
  logic                  b_v_r, b_act_r, b_sch_r, b_hi_r, b_fz_r;
  logic [XW-1:0]         b_f_r, b_x_r;
  logic [SW-1:0]         b_side_r;
  logic signed [PRW-1:0] b_p1_r;
  logic [P2W-1:0]        b_p2_r;
  logic signed [XW+1:0]  t1;
  logic signed [XW:0]    t2;

  assign t1 = $signed({2'b00, ONE}) - $signed({1'b0, a_f_r, 1'b0});
  assign t2 = $signed({1'b0, ONE - a_xp_r});

  // stage C: denominator and numerator
  logic                  c_v_r;
  dside_t                c_ds_r;
  logic [NUMW-1:0]       c_num_r;
  logic [DENW-1:0]       c_den_r;
  logic signed [PRW-1:0] dsum;

  assign dsum = b_p1_r + $signed(PRW'({b_f_r, {F{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_act_r  <= in_act;
      a_sch_r  <= in_sch;
      a_hi_r   <= a_hi_nxt;
      a_f_r    <= a_f_nxt;
      a_xp_r   <= a_xp_nxt;
      a_x_r    <= in_x;
      a_side_r <= in_side;

      b_act_r  <= a_act_r;
      b_sch_r  <= a_sch_r;
      b_hi_r   <= a_hi_r;
      b_fz_r   <= a_f_r == '0;
      b_f_r    <= a_f_r;
      b_x_r    <= a_x_r;
      b_side_r <= a_side_r;
      b_p1_r   <= t1 * t2;
      b_p2_r   <= a_xp_r * a_f_r;

      c_ds_r.act  <= b_act_r;
      c_ds_r.sch  <= b_sch_r;
      c_ds_r.hi   <= b_hi_r;
      // zero factor or a non-positive denominator gives zero
      c_ds_r.bad  <= b_fz_r || dsum[PRW-1] || (dsum == '0);
      c_ds_r.x    <= b_x_r;
      c_ds_r.side <= b_side_r;
      c_num_r     <= {b_p2_r, {F{1'b0}}};
      c_den_r     <= dsum[DENW-1:0];
    end
  end

  logic          d_v;
  logic [XW-1:0] d_quo;
  logic          d_ovf;
  dside_t        d_ds;

  rrgb_div #(
    .NW(NUMW),
    .DW(DENW),
    .QW(XW),
    .SW($bits(dside_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (c_v_r),
    .in_num  (c_num_r),
    .in_den  (c_den_r),
    .in_side (c_ds_r),
    .out_v   (d_v),
    .out_quo (d_quo),
    .out_ovf (d_ovf),
    .out_side(d_ds)
  );

  // stage D: cap, fold the Schlick halves back, or pass through
  logic          o_v_r;
  logic [XW-1:0] o_x_r, q0, shaped;
  logic [SW-1:0] o_side_r;

  always_comb begin
    if (d_ds.bad) q0 = '0;
    else if (d_ovf || (d_quo > ONE)) q0 = ONE;
    else q0 = d_quo;
    if (!d_ds.act) shaped = d_ds.x;
    else if (d_ds.sch) shaped = (q0 >> 1) + (d_ds.hi ? HALF : '0);
    else shaped = q0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= d_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x_r    <= shaped;
      o_side_r <= d_ds.side;
    end
  end

  assign out_v    = o_v_r;
  assign out_x    = o_x_r;
  assign out_side = o_side_r;

endmodule

### rtl/range_remap_gain_bias.sv
// ----------------------------------------------------------------------------
// range_remap_gain_bias
// Remaps signed fixed-point samples from an input range to an output range,
// with optional clamping and Schlick gain / bias shaping in between.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | sink      | in_valid/in_stall | in_sample_value, in_sample_present
//  out     | source    | out_valid/stall   | out_mapped_value, out_value_valid
//  cfg     | sink      | cfg_we            | cfg_addr, cfg_wdata
//
//  One request enters per clock while no result is stalled at the output;
//  the path runs through three bit-serial divider pipelines: the
//  normalizing divide (41 quotient stages) and one divide per shaping step
//  (FRAC_BITS+1 quotient stages each).
//  Reset clears every valid bit and loads the register defaults.
//  A stalled result holds the whole pipeline; in_stall rises only while a
//  result sits in the output register and is stalled.
// ----------------------------------------------------------------------------
module range_remap_gain_bias #(
  parameter int FRAC_BITS = rrgb_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rrgb_pkg::DATA_W-1:0]   in_sample_value,
  input  logic                                 in_sample_present,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rrgb_pkg::DATA_W-1:0]   out_mapped_value,
  output logic                                 out_value_valid,
  input  logic                                 cfg_we,
  input  logic [rrgb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rrgb_pkg::DATA_W-1:0]          cfg_wdata
);
  import rrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int XW = F + 1;          // normalized value, 0..1 inclusive
  localparam int PW = 2 * EXT_W;      // full product width
  localparam int HW = EXT_W - SPLIT_W;
  localparam int TW = F + 19;         // threshold compare width
  localparam int MW = EXT_W + 1;      // magnitude width
  localparam int RW = MW + 2;         // result width before saturation
  localparam logic [XW-1:0] ONE      = {1'b1, {F{1'b0}}};
  localparam logic [TW-1:0] TH_ONE   = TW'(999) << F;
  localparam logic [TW-1:0] TH_ZERO  = TW'(1) << F;
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] il_r, ih_r, ol_r, oh_r;
  logic [FACT_W-1:0]        gain_r, bias_r;
  logic                     clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      il_r    <= '0;
      ih_r    <= DATA_W'(FACT_ONE);
      ol_r    <= '0;
      oh_r    <= DATA_W'(FACT_ONE);
      gain_r  <= FACT_W'(FACT_HALF);
      bias_r  <= FACT_W'(FACT_HALF);
      clamp_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_INPUT_LOW:   il_r    <= cfg_wdata;
        CFG_INPUT_HIGH:  ih_r    <= cfg_wdata;
        CFG_OUTPUT_LOW:  ol_r    <= cfg_wdata;
        CFG_OUTPUT_HIGH: oh_r    <= cfg_wdata;
        CFG_GAIN:        gain_r  <= cfg_wdata[FACT_W-1:0];
        CFG_BIAS:        bias_r  <= cfg_wdata[FACT_W-1:0];
        CFG_CLAMP:       clamp_r <= cfg_wdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // clip factors to one and rescale to the fraction width
  logic [FACT_W-1:0]   gain_c, bias_c;
  logic [FACT_W+F-1:0] g_wide, b_wide;
  logic [XW-1:0]       g_fac, b_fac;
  logic                bias_first;

  assign gain_c     = (gain_r > FACT_W'(FACT_ONE)) ? FACT_W'(FACT_ONE) : gain_r;
  assign bias_c     = (bias_r > FACT_W'(FACT_ONE)) ? FACT_W'(FACT_ONE) : bias_r;
  assign g_wide     = {gain_c, {F{1'b0}}} >> 16;
  assign b_wide     = {bias_c, {F{1'b0}}} >> 16;
  assign g_fac      = g_wide[XW-1:0];
  assign b_fac      = b_wide[XW-1:0];
  // a gain below one half runs bias first, then Schlick
  assign bias_first = gain_c < FACT_W'(FACT_HALF);

  // --------------------------------------------------------------------------
  // pipeline advance: hold everything while the output request is stalled
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 0: input register
  logic                     v0_r, p0_r;
  logic signed [DATA_W-1:0] x0_r;

  // stage 1: differences
  logic                    v1_r, p1_r;
  logic signed [EXT_W-1:0] a1_r, den1_r, d1_r;

  // stage 2: magnitudes and signs
  logic             v2_r;
  logic [EXT_W-1:0] aabs2_r, denabs2_r;
  front_t           fr2_r;

  // stage 3: partial products
  logic                   v3_r;
  logic [EXT_W-1:0]       aabs3_r, denabs3_r;
  front_t                 fr3_r;
  logic [2*SPLIT_W-1:0]   ll3_r;
  logic [SPLIT_W+HW-1:0]  lh3_r, hl3_r;
  logic [2*HW-1:0]        hh3_r;

  // stage 4: divider operands
  logic             v4_r;
  logic [PW-1:0]    num4_r;
  logic [EXT_W-1:0] den4_r;
  front_t           fr4_r;
  logic [PW-1:0]    prod4;

  assign prod4 = PW'(ll3_r)
               + (PW'(lh3_r) << SPLIT_W)
               + (PW'(hl3_r) << SPLIT_W)
               + (PW'(hh3_r) << (2 * SPLIT_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_sample_value;
      p0_r <= in_sample_present;

      a1_r   <= EXT_W'(x0_r) - EXT_W'(il_r);
      den1_r <= EXT_W'(ih_r) - EXT_W'(il_r);
      d1_r   <= EXT_W'(oh_r) - EXT_W'(ol_r);
      p1_r   <= p0_r;

      aabs2_r    <= a1_r[EXT_W-1] ? EXT_W'(-a1_r) : EXT_W'(a1_r);
      denabs2_r  <= den1_r[EXT_W-1] ? EXT_W'(-den1_r) : EXT_W'(den1_r);
      fr2_r.dabs <= d1_r[EXT_W-1] ? EXT_W'(-d1_r) : EXT_W'(d1_r);
      fr2_r.bad  <= !p1_r || (den1_r == '0);
      fr2_r.cz   <= ((a1_r <= 0) && (den1_r > 0)) || ((a1_r >= 0) && (den1_r < 0));
      fr2_r.cone <= 1'b0;
      fr2_r.uneg <= a1_r[EXT_W-1] ^ d1_r[EXT_W-1] ^ den1_r[EXT_W-1];
      fr2_r.dneg <= d1_r[EXT_W-1];

      aabs3_r    <= aabs2_r;
      denabs3_r  <= denabs2_r;
      fr3_r      <= '{bad: fr2_r.bad, cz: fr2_r.cz, cone: aabs2_r >= denabs2_r,
                      uneg: fr2_r.uneg, dneg: fr2_r.dneg, dabs: fr2_r.dabs};
      ll3_r      <= aabs2_r[SPLIT_W-1:0] * fr2_r.dabs[SPLIT_W-1:0];
      lh3_r      <= aabs2_r[SPLIT_W-1:0] * fr2_r.dabs[EXT_W-1:SPLIT_W];
      hl3_r      <= aabs2_r[EXT_W-1:SPLIT_W] * fr2_r.dabs[SPLIT_W-1:0];
      hh3_r      <= aabs2_r[EXT_W-1:SPLIT_W] * fr2_r.dabs[EXT_W-1:SPLIT_W];

      // clamped mode divides |a| * ONE, unclamped mode |a| * |d|
      num4_r <= clamp_r ? (PW'(aabs3_r) << F) : prod4;
      den4_r <= denabs3_r;
      fr4_r  <= fr3_r;
    end
  end

  // --------------------------------------------------------------------------
  // normalizing / remapping divide
  // --------------------------------------------------------------------------
  logic             v5d;
  logic [EXT_W-1:0] q5d;
  logic             ovf5d;
  front_t           fr5d;

  rrgb_div #(
    .NW(PW),
    .DW(EXT_W),
    .QW(EXT_W),
    .SW($bits(front_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v4_r),
    .in_num  (num4_r),
    .in_den  (den4_r),
    .in_side (fr4_r),
    .out_v   (v5d),
    .out_quo (q5d),
    .out_ovf (ovf5d),
    .out_side(fr5d)
  );

  // stage 5: clamp the normalized value to [0,1]
  logic          v5_r;
  logic [XW-1:0] n5_r;
  side_t         sd5_r;

  // stage 6: snap near one and near zero, decide on shaping
  logic          v6_r;
  logic [XW-1:0] n6_r;
  side_t         sd6_r;
  logic [TW-1:0] m1000, m100k;
  logic          th_one, th_zero;

  assign m1000   = TW'(n5_r) * TW'(1000);
  assign m100k   = TW'(n5_r) * TW'(100000);
  assign th_one  = m1000 > TH_ONE;
  assign th_zero = m100k < TH_ZERO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= v5d;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fr5d.cz) n5_r <= '0;
      else if (fr5d.cone) n5_r <= ONE;
      else n5_r <= {1'b0, q5d[F-1:0]};
      sd5_r.act  <= 1'b0;
      sd5_r.bad  <= fr5d.bad;
      sd5_r.uneg <= fr5d.uneg;
      sd5_r.dneg <= fr5d.dneg;
      sd5_r.dabs <= fr5d.dabs;
      sd5_r.uovf <= ovf5d;
      sd5_r.uq   <= q5d;

      sd6_r <= '{act: clamp_r && !sd5_r.bad && !th_one && !th_zero,
                 bad: sd5_r.bad, uneg: sd5_r.uneg, dneg: sd5_r.dneg,
                 dabs: sd5_r.dabs, uovf: sd5_r.uovf, uq: sd5_r.uq};
      if (clamp_r && th_one) n6_r <= ONE;
      else if (clamp_r && th_zero) n6_r <= '0;
      else n6_r <= n5_r;
    end
  end

  // --------------------------------------------------------------------------
  // two shaping steps, order set by the gain
  // --------------------------------------------------------------------------
  logic          v_s1, v_s2;
  logic [XW-1:0] n_s1, n_s2;
  side_t         sd_s1, sd_s2;

  rrgb_shape #(
    .FRAC_BITS(F),
    .SW($bits(side_t))
  ) u_shape_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v6_r),
    .in_act  (sd6_r.act),
    .in_sch  (!bias_first),
    .in_fac  (bias_first ? b_fac : g_fac),
    .in_x    (n6_r),
    .in_side (sd6_r),
    .out_v   (v_s1),
    .out_x   (n_s1),
    .out_side(sd_s1)
  );

  rrgb_shape #(
    .FRAC_BITS(F),
    .SW($bits(side_t))
  ) u_shape_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_s1),
    .in_act  (sd_s1.act),
    .in_sch  (bias_first),
    .in_fac  (bias_first ? g_fac : b_fac),
    .in_x    (n_s1),
    .in_side (sd_s1),
    .out_v   (v_s2),
    .out_x   (n_s2),
    .out_side(sd_s2)
  );

  // --------------------------------------------------------------------------
  // map into the output range and saturate
  // --------------------------------------------------------------------------
  // stage 7: n * |d| as two partial products
  logic                  v7_r;
  side_t                 sd7_r;
  logic [XW+SPLIT_W-1:0] nl7_r;
  logic [XW+HW-1:0]      nh7_r;

  // stage 8: offset magnitude and direction
  logic          v8_r, bad8_r, neg8_r;
  logic [MW-1:0] mag8_r;
  logic [PW-1:0] prod_c, scaled_c;

  assign prod_c   = PW'(nl7_r) + (PW'(nh7_r) << SPLIT_W);
  assign scaled_c = prod_c >> F;

  // stage 9: output register
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_vv_r;
  logic signed [RW-1:0]     ol_ext, mag_ext, res9;

  assign ol_ext  = RW'(ol_r);
  assign mag_ext = $signed(RW'(mag8_r));
  assign res9    = neg8_r ? (ol_ext - mag_ext) : (ol_ext + mag_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v7_r        <= v_s2;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd7_r <= sd_s2;
      nl7_r <= n_s2 * sd_s2.dabs[SPLIT_W-1:0];
      nh7_r <= n_s2 * sd_s2.dabs[EXT_W-1:SPLIT_W];

      bad8_r <= sd7_r.bad;
      if (clamp_r) begin
        mag8_r <= scaled_c[MW-1:0];
        neg8_r <= sd7_r.dneg;
      end else begin
        // an overflowed quotient saturates the result either way
        mag8_r <= sd7_r.uovf ? {1'b1, {EXT_W{1'b0}}} : {1'b0, sd7_r.uq};
        neg8_r <= sd7_r.uneg;
      end

      if (bad8_r) begin
        out_value_r <= '0;
        out_vv_r    <= 1'b0;
      end else begin
        out_vv_r <= 1'b1;
        if (res9 > SAT_HI) out_value_r <= SAT_HI[DATA_W-1:0];
        else if (res9 < SAT_LO) out_value_r <= SAT_LO[DATA_W-1:0];
        else out_value_r <= res9[DATA_W-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_value = out_value_r;
  assign out_value_valid  = out_vv_r;

endmodule

### rtl/rrgb_chk.sv
// ----------------------------------------------------------------------------
// rrgb_chk
// Port-level checks for the range remap block, bound to its top level.
// ----------------------------------------------------------------------------
module rrgb_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [rrgb_pkg::DATA_W-1:0]        in_sample_value,
  input logic                               in_sample_present,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [rrgb_pkg::DATA_W-1:0]        out_mapped_value,
  input logic                               out_value_valid
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mapped_value)
                               && $stable(out_value_valid))
    else $error("stalled result changed");

  // a stalled request holds on the input side
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_sample_value)
                             && $stable(in_sample_present))
    else $error("stalled request changed");

  // a result marked not valid carries zero
  a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_valid |-> out_mapped_value == '0)
    else $error("invalid result with nonzero value");

  // input backpressure only while the output request is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind range_remap_gain_bias rrgb_chk u_rrgb_chk (.*);

### bench/rrgb_check.sv
// ----------------------------------------------------------------------------
// rrgb_check
// Watches the sample, result and register ports of the range remap block.
// Keeps its own copy of the registers and predicts the remapped value of
// every accepted request. Compares each result, in order, with that
// prediction.
// ----------------------------------------------------------------------------
module rrgb_check
  import rrgb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic                     in_sample_present,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_mapped_value,
  input  logic                     out_value_valid,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output int                       fail_count,
  output int                       results_owed
);

  localparam int FB = DEF_FRAC_BITS;
  localparam longint ONE = longint'(1) << FB;
  localparam longint HALF = ONE >> 1;
  localparam longint VMAX = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint VMIN = -(longint'(1) << (DATA_W - 1));

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     ok;
  } mapped_t;

  logic signed [DATA_W-1:0] in_lo, in_hi, out_lo, out_hi;
  logic [FACT_W-1:0]        gain, bias;
  logic                     clamp_on;
  mapped_t                  mapped_q[$];

  // a*b/d with a 128-bit product, saturating when the quotient is wider
  function automatic longint unsigned mul_div(longint unsigned a, longint unsigned b,
                                              longint unsigned d);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    if (d == 0) return 0;
    if (p[127:64] >= d) return '1;
    q = p / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic longint unsigned bias_curve(longint unsigned b, longint unsigned x);
    longint den;
    longint unsigned q;
    if (b == 0) return 0;
    den = (ONE - 2 * longint'(b)) * (ONE - longint'(x)) + longint'(b) * ONE;
    if (den <= 0) return 0;
    q = mul_div(x * b, ONE, den);
    return (q > ONE) ? ONE : q;
  endfunction

  function automatic longint unsigned schlick_curve(longint unsigned g, longint unsigned x);
    if (x < HALF) return bias_curve(g, 2 * x) >> 1;
    return (bias_curve(ONE - g, 2 * x - ONE) >> 1) + HALF;
  endfunction

  function automatic longint unsigned shape_norm(longint unsigned n);
    longint unsigned gr, br, g, b;
    gr = (gain > FACT_ONE) ? FACT_ONE : gain;
    br = (bias > FACT_ONE) ? FACT_ONE : bias;
    g = (gr << FB) >> 16;
    b = (br << FB) >> 16;
    if (n * 1000 > 999 * ONE) return ONE;
    if (n * 100000 < ONE) return 0;
    if (gr < FACT_HALF) return schlick_curve(g, bias_curve(b, n));
    return bias_curve(b, schlick_curve(g, n));
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic mapped_t remap(logic signed [DATA_W-1:0] sample, logic present);
    longint x, il, ol, span_in, off, span_out, res;
    longint unsigned m, n;
    logic neg;
    mapped_t r;
    x = sample;
    il = in_lo;
    ol = out_lo;
    span_in = longint'(in_hi) - il;
    off = x - il;
    span_out = longint'(out_hi) - ol;
    r.value = '0;
    r.ok = 1'b0;
    if (!present || span_in == 0) return r;
    if (clamp_on) begin
      if ((off <= 0 && span_in > 0) || (off >= 0 && span_in < 0)) n = 0;
      else if (mag(off) >= mag(span_in)) n = ONE;
      else n = mul_div(mag(off), ONE, mag(span_in));
      n = shape_norm(n);
      m = mul_div(n, mag(span_out), ONE);
      neg = span_out < 0;
    end else begin
      m = mul_div(mag(off), mag(span_out), mag(span_in));
      neg = (off < 0) != ((span_out < 0) != (span_in < 0));
    end
    if (m > (longint'(1) << 41)) m = longint'(1) << 41;
    res = neg ? ol - longint'(m) : ol + longint'(m);
    if (res > VMAX) res = VMAX;
    if (res < VMIN) res = VMIN;
    r.value = res[DATA_W-1:0];
    r.ok = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    mapped_t e;
    if (!rst_n) begin
      in_lo <= '0;
      in_hi <= DATA_W'(FACT_ONE);
      out_lo <= '0;
      out_hi <= DATA_W'(FACT_ONE);
      gain <= FACT_W'(FACT_HALF);
      bias <= FACT_W'(FACT_HALF);
      clamp_on <= 1'b0;
      mapped_q.delete();
      fail_count <= 0;
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_INPUT_LOW:   in_lo <= cfg_wdata;
          CFG_INPUT_HIGH:  in_hi <= cfg_wdata;
          CFG_OUTPUT_LOW:  out_lo <= cfg_wdata;
          CFG_OUTPUT_HIGH: out_hi <= cfg_wdata;
          CFG_GAIN:        gain <= cfg_wdata[FACT_W-1:0];
          CFG_BIAS:        bias <= cfg_wdata[FACT_W-1:0];
          CFG_CLAMP:       clamp_on <= cfg_wdata[0];
          default: ;
        endcase
      end
      // compare the oldest prediction with the result leaving the block
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          $error("result with no request outstanding: mapped_value %0d", out_mapped_value);
          fail_count <= fail_count + 1;
        end else begin
          e = mapped_q.pop_front();
          if (out_mapped_value !== e.value || out_value_valid !== e.ok) begin
            if (out_mapped_value !== e.value)
              $error("mapped_value mismatch: expected %0d, got %0d", e.value,
                     out_mapped_value);
            if (out_value_valid !== e.ok)
              $error("value_valid mismatch: expected %0b, got %0b", e.ok,
                     out_value_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
      // append the prediction for a newly accepted request
      if (in_valid && !in_stall)
        mapped_q.insert(mapped_q.size(), remap(in_sample_value, in_sample_present));
      results_owed <= mapped_q.size();
    end
  end

endmodule

### bench/range_remap_gain_bias_test.sv
// ----------------------------------------------------------------------------
// range_remap_gain_bias_test
// Stimulus for the range remap block: directed corner requests on the reset
// register values and on extreme settings, then random phases. Each phase
// loads new registers while the block is idle and runs under its own mix of
// sender gaps and receiver stalls. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module range_remap_gain_bias_test;
  import rrgb_pkg::*;

  localparam int LATENCY = 2 * DEF_FRAC_BITS + 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 110;
  localparam longint ONE = longint'(1) << DEF_FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_sample_present;
  logic signed [DATA_W-1:0] in_sample_value;
  logic out_valid, out_stall, out_value_valid;
  logic signed [DATA_W-1:0] out_mapped_value;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0] cfg_wdata;
  int fail_count, results_owed;
  int send_gap_pct, recv_stall_pct;
  int quiet_cycles;
  // shadow of the input range, used to aim samples into it
  longint range_lo, range_hi;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  range_remap_gain_bias DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_value, .in_sample_present,
    .out_valid, .out_stall, .out_mapped_value, .out_value_valid,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  rrgb_check checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_value, .in_sample_present,
    .out_valid, .out_stall, .out_mapped_value, .out_value_valid,
    .cfg_we, .cfg_addr, .cfg_wdata, .fail_count, .results_owed
  );

  // stall the result channel at the current phase's rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: count cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[DATA_W-1:0];
  endfunction

  // mostly modest values, sometimes the full 40-bit span
  function automatic longint rand_level();
    longint v;
    case ($urandom_range(3))
      0: v = longint'($signed(rand40()));
      1: v = longint'($signed({$urandom_range(1) ? 20'hFFFFF : 20'h0,
                               20'($urandom_range(1048575))}));
      default: v = longint'($urandom_range(8 * 65536)) - 4 * 65536;
    endcase
    return v;
  endfunction

  // hold a request until accepted; insert gaps ahead of it at the phase's rate
  task automatic send(longint value, logic present);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= value[DATA_W-1:0];
    in_sample_present <= present;
    do @(posedge clk); while (in_stall);
  endtask

  // aim most samples into the input range, some at or just past its ends
  task automatic send_random();
    longint span, pos, v;
    span = range_hi - range_lo;
    case ($urandom_range(7))
      0: v = longint'($signed(rand40()));
      1: v = range_lo + longint'($urandom_range(4000)) - 2000;
      2: v = range_hi + longint'($urandom_range(4000)) - 2000;
      default: begin
        pos = range_lo + (span * longint'($urandom_range(65536))) / 65536;
        v = pos;
      end
    endcase
    send(v, $urandom_range(15) != 0);
  endtask

  // let the pipeline drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, longint data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data[DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INPUT_LOW) range_lo = data;
    if (idx == CFG_INPUT_HIGH) range_hi = data;
  endtask

  task automatic load_ranges(longint il, longint ih, longint ol, longint oh);
    write_reg(CFG_INPUT_LOW, il);
    write_reg(CFG_INPUT_HIGH, ih);
    write_reg(CFG_OUTPUT_LOW, ol);
    write_reg(CFG_OUTPUT_HIGH, oh);
  endtask

  task automatic load_shape(longint g, longint b, logic clamp);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_BIAS, b);
    write_reg(CFG_CLAMP, longint'(clamp));
  endtask

  initial begin
    longint vmax, vmin;
    vmax = (longint'(1) << (DATA_W - 1)) - 1;
    vmin = -(longint'(1) << (DATA_W - 1));
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_value <= '0;
    in_sample_present <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_INPUT_LOW;
    cfg_wdata <= '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    range_lo = 0;
    range_hi = ONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: unit range, no shaping
    send(0, 1'b1);
    send(ONE, 1'b1);
    send(ONE / 2, 1'b1);
    send(vmax, 1'b1);
    send(vmin, 1'b1);
    send(ONE / 3, 1'b0);
    drain();

    // clamp and shape: gain order, zero bias, vanishing denominator, factors above one
    load_ranges(0, ONE, vmin, vmax);
    load_shape(0, 0, 1'b1);
    send(ONE / 4, 1'b1);
    send(-5, 1'b1);
    send(ONE + 5, 1'b1);
    drain();
    load_shape(FACT_ONE, FACT_ONE, 1'b1);
    send(ONE / 4, 1'b1);
    send(3 * ONE / 4, 1'b1);
    send(ONE * 999 / 1000 + 1, 1'b1);
    send(1, 1'b1);
    drain();
    load_shape((1 << FACT_W) - 1, (1 << FACT_W) - 1, 1'b1);
    send(ONE / 2, 1'b1);
    send(ONE / 10, 1'b1);
    drain();

    // empty input range, with and without clamp; then overflow of the unclamped map
    load_ranges(vmax, vmax, 0, ONE);
    send(vmax, 1'b1);
    drain();
    write_reg(CFG_CLAMP, 0);
    send(0, 1'b1);
    drain();
    load_ranges(0, 1, vmax, vmin);
    send(vmax, 1'b1);
    send(vmin, 1'b1);
    send(0, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // rotate through the gap and stall mixes
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 79; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 79; end
        default: begin send_gap_pct = 16; recv_stall_pct = 16; end
      endcase
      load_ranges(rand_level(), rand_level(), rand_level(), rand_level());
      load_shape($urandom_range(2) == 0 ? longint'($urandom_range(131071))
                                        : longint'($urandom_range(65536)),
                 $urandom_range(7) == 0 ? longint'(0) : longint'($urandom_range(65536)),
                 ph % 3 != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
    end

    recv_stall_pct = 0;
    wait (results_owed == 0);
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
